// ===== rtl/sensor_fusion_health_monitor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor fusion health monitor
// Same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FUSION_HEALTH_MONITOR_UNIT_ASSERT_SVH
`define SENSOR_FUSION_HEALTH_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SFHM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfhm assertion failed");

// next-cycle implication
`define SFHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfhm assertion failed");

`endif

// ===== rtl/sfhm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfhm_pkg
// Status codes, operation codes and register constants of the health monitor.
// ----------------------------------------------------------------------------
package sfhm_pkg;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_SAFE     = 2'd1,
        ST_REINIT   = 2'd2,
        ST_FAILSAFE = 2'd3
    } t_status;

    localparam logic [1:0] OP_VISION = 2'd0;
    localparam logic [1:0] OP_IMU    = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [1:0] STG_TRACK = 2'd0;
    localparam logic [1:0] STG_RELOC = 2'd1;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_NEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REINIT_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMU_TO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_TO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS    = 3'd7;

    localparam logic [7:0]         RST_STABLE_NEED = 8'd15;
    localparam logic [15:0]        RST_TIMEOUT_MS  = 16'd1000;
    localparam logic signed [31:0] RST_SCALE_DIV   = 32'sd524288;
    localparam logic signed [31:0] RST_SCALE_MAX   = 32'sd327680;
    localparam logic signed [31:0] RST_SCALE_MIN   = 32'sd13107;
    localparam logic signed [15:0] QUAT_ONE        = 16'sd16384;

endpackage

// ===== rtl/sensor_fusion_health_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_fusion_health_monitor_unit
// Watchdog for a visual-inertial estimator: vision, IMU and commit items.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_ready) takes one item per cycle while
//  o_in_ready is high: a vision report, an IMU sample or a commit. Only a
//  commit yields a result item on the output channel (o_out_valid /
//  i_out_ready); other items update state. Configuration writes use
//  i_cfg_valid / o_cfg_ready with a 3-bit index and 32-bit data; o_cfg_ready
//  is always high. Write only while idle.
//  An accepted item is registered, then processed; a commit's result is
//  registered in the result register, which drives o_out_valid.
//  Throughput: one item per cycle while o_in_ready is high; the work is
//  subtract-and-compare steps on 32-bit times and signed scale compares
//  between the input and result registers.
//  Reset (synchronous, i_rst_n low): registers take their default values,
//  timers restart at time zero, the held orientation becomes identity and
//  both pipeline registers empty.
//  Receiver stall: the result register holds its item; vision and IMU items
//  keep flowing, a commit waits in the input register until the result
//  register frees, and o_in_ready drops only then.
// ----------------------------------------------------------------------------
module sensor_fusion_health_monitor_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic [31:0]        i_timestamp_ms,
    input  logic [1:0]         i_vision_stage,
    input  logic signed [31:0] i_scale_estimate,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_verdict,
    output logic [1:0]         o_vision_health,
    output logic [1:0]         o_imu_health,
    output logic [1:0]         o_filter_health,
    output logic signed [15:0] o_reinit_w,
    output logic signed [15:0] o_reinit_x,
    output logic signed [15:0] o_reinit_y,
    output logic signed [15:0] o_reinit_z
);
    import sfhm_pkg::*;

    // configuration
    logic [7:0]         r_stable_need;
    logic [15:0]        r_reinit_ms;
    logic [15:0]        r_imu_to;
    logic [15:0]        r_vis_to;
    logic signed [31:0] r_scale_div;
    logic signed [31:0] r_scale_max;
    logic signed [31:0] r_scale_min;
    logic [15:0]        r_dwell_ms;

    // input register
    logic               r_in_vld;
    logic [1:0]         r_op;
    logic [31:0]        r_ts;
    logic [1:0]         r_stage;
    logic signed [31:0] r_scale;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    // monitor state
    t_status            r_vis_st, n_vis_st;
    logic [7:0]         r_stable_cnt, n_stable_cnt;
    logic [31:0]        r_last_vis, n_last_vis;
    logic [31:0]        r_last_imu, n_last_imu;
    logic [31:0]        r_band_time, n_band_time;
    logic [31:0]        r_reloc, n_reloc;
    logic signed [15:0] r_held_w, r_held_x, r_held_y, r_held_z;

    // result register
    logic               r_out_vld;
    t_status            r_verdict, n_verdict;
    t_status            r_vis_h;
    t_status            r_imu_h, n_imu_h;
    t_status            r_flt_h, n_flt_h;
    logic signed [15:0] r_out_w, r_out_x, r_out_y, r_out_z;

    logic        out_free;
    logic        is_commit;
    logic        adv;
    logic        do_commit;
    logic [31:0] vis_age;
    logic [31:0] imu_age;
    logic [31:0] band_age;
    logic [32:0] reloc_sum;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || i_out_ready;
    assign is_commit   = (r_op == OP_COMMIT);
    assign adv         = r_in_vld && (!is_commit || out_free);
    assign do_commit   = adv && is_commit;
    assign o_in_ready  = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_need <= RST_STABLE_NEED;
            r_reinit_ms   <= RST_TIMEOUT_MS;
            r_imu_to      <= RST_TIMEOUT_MS;
            r_vis_to      <= RST_TIMEOUT_MS;
            r_scale_div   <= RST_SCALE_DIV;
            r_scale_max   <= RST_SCALE_MAX;
            r_scale_min   <= RST_SCALE_MIN;
            r_dwell_ms    <= RST_TIMEOUT_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STABLE_NEED: r_stable_need <= i_cfg_data[7:0];
                CFG_REINIT_MS:   r_reinit_ms   <= i_cfg_data[15:0];
                CFG_IMU_TO:      r_imu_to      <= i_cfg_data[15:0];
                CFG_VIS_TO:      r_vis_to      <= i_cfg_data[15:0];
                CFG_SCALE_DIV:   r_scale_div   <= $signed(i_cfg_data);
                CFG_SCALE_MAX:   r_scale_max   <= $signed(i_cfg_data);
                CFG_SCALE_MIN:   r_scale_min   <= $signed(i_cfg_data);
                CFG_DWELL_MS:    r_dwell_ms    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op    <= i_operation;
            r_ts    <= i_timestamp_ms;
            r_stage <= i_vision_stage;
            r_scale <= i_scale_estimate;
            r_qw    <= i_quat_w;
            r_qx    <= i_quat_x;
            r_qy    <= i_quat_y;
            r_qz    <= i_quat_z;
        end
    end

    assign vis_age   = r_ts - r_last_vis;
    assign imu_age   = r_ts - r_last_imu;
    assign band_age  = r_ts - r_band_time;
    assign reloc_sum = {1'b0, r_reloc} + {1'b0, vis_age};

    always_comb begin
        n_vis_st     = r_vis_st;
        n_stable_cnt = r_stable_cnt;
        n_last_vis   = r_last_vis;
        n_last_imu   = r_last_imu;
        n_band_time  = r_band_time;
        n_reloc      = r_reloc;
        n_imu_h      = ST_SAFE;
        n_flt_h      = ST_NONE;
        n_verdict    = ST_NONE;
        if (adv && r_op == OP_VISION) begin
            n_last_vis = r_ts;
            case (r_stage)
                STG_TRACK: begin
                    n_reloc = '0;
                    if (r_stable_cnt < r_stable_need) begin
                        n_stable_cnt = r_stable_cnt + 8'd1;
                        n_vis_st     = ST_NONE;
                    end else begin
                        n_vis_st = ST_SAFE;
                    end
                end
                STG_RELOC: begin
                    n_reloc  = reloc_sum[32] ? '1 : reloc_sum[31:0];
                    n_vis_st = (n_reloc > {16'd0, r_reinit_ms}) ? ST_REINIT : ST_NONE;
                end
                default: begin
                    n_reloc      = '0;
                    n_stable_cnt = '0;
                    n_vis_st     = ST_NONE;
                end
            endcase
        end
        if (adv && r_op == OP_IMU) begin
            n_last_imu = r_ts;
        end
        if (do_commit) begin
            if (vis_age > {16'd0, r_vis_to}) begin
                n_vis_st = ST_FAILSAFE;
            end
            n_imu_h = (imu_age > {16'd0, r_imu_to}) ? ST_REINIT : ST_SAFE;
            if (n_vis_st != ST_SAFE) begin
                n_band_time = r_ts;
                n_flt_h     = ST_NONE;
            end else if (r_scale >= r_scale_min && r_scale <= r_scale_max) begin
                n_band_time = r_ts;
                n_flt_h     = ST_SAFE;
            end else if (r_scale < r_scale_div && r_scale > r_scale_max) begin
                if (band_age < {16'd0, r_dwell_ms}) begin
                    n_flt_h = ST_NONE;
                end else begin
                    n_band_time = r_ts;
                    n_flt_h     = ST_REINIT;
                end
            end else begin
                n_band_time = r_ts;
                n_flt_h     = ST_REINIT;
            end
            if (n_vis_st == ST_REINIT || n_imu_h == ST_REINIT || n_flt_h == ST_REINIT) begin
                n_verdict = ST_REINIT;
            end else if (n_vis_st == ST_SAFE && n_imu_h == ST_SAFE && n_flt_h == ST_SAFE) begin
                n_verdict = ST_SAFE;
            end else begin
                n_verdict = ST_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_st     <= ST_NONE;
            r_stable_cnt <= '0;
            r_last_vis   <= '0;
            r_last_imu   <= '0;
            r_band_time  <= '0;
            r_reloc      <= '0;
            r_held_w     <= QUAT_ONE;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_z     <= '0;
        end else begin
            r_vis_st     <= n_vis_st;
            r_stable_cnt <= n_stable_cnt;
            r_last_vis   <= n_last_vis;
            r_last_imu   <= n_last_imu;
            r_band_time  <= n_band_time;
            r_reloc      <= n_reloc;
            if (adv && r_op == OP_IMU) begin
                r_held_w <= r_qw;
                r_held_x <= r_qx;
                r_held_y <= r_qy;
                r_held_z <= r_qz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= do_commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_commit) begin
            r_verdict <= n_verdict;
            r_vis_h   <= n_vis_st;
            r_imu_h   <= n_imu_h;
            r_flt_h   <= n_flt_h;
            r_out_w   <= r_held_w;
            r_out_x   <= r_held_x;
            r_out_y   <= r_held_y;
            r_out_z   <= r_held_z;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_verdict       = r_verdict;
    assign o_vision_health = r_vis_h;
    assign o_imu_health    = r_imu_h;
    assign o_filter_health = r_flt_h;
    assign o_reinit_w      = r_out_w;
    assign o_reinit_x      = r_out_x;
    assign o_reinit_y      = r_out_y;
    assign o_reinit_z      = r_out_z;

endmodule

// ===== rtl/sfhm_checker.sv =====
// ----------------------------------------------------------------------------
// sfhm_checker
// Port-level checks of the health monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensor_fusion_health_monitor_unit_assert.svh"

module sfhm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_verdict,
    input logic [1:0] o_vision_health,
    input logic [1:0] o_imu_health,
    input logic [1:0] o_filter_health
);
    import sfhm_pkg::*;

    `SFHM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `SFHM_ASSERT_NOW(a_safe_all, i_clk, i_rst_n, o_out_valid && o_verdict == ST_SAFE, o_vision_health == ST_SAFE && o_imu_health == ST_SAFE && o_filter_health == ST_SAFE)

    `SFHM_ASSERT_NOW(a_reinit_any, i_clk, i_rst_n, o_out_valid && (o_vision_health == ST_REINIT || o_imu_health == ST_REINIT || o_filter_health == ST_REINIT), o_verdict == ST_REINIT)

    `SFHM_ASSERT_NOW(a_imu_range, i_clk, i_rst_n, o_out_valid, o_imu_health == ST_SAFE || o_imu_health == ST_REINIT)

endmodule

bind sensor_fusion_health_monitor_unit sfhm_checker u_sfhm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_verdict       (o_verdict),
    .o_vision_health (o_vision_health),
    .o_imu_health    (o_imu_health),
    .o_filter_health (o_filter_health)
);
